### rtl/esad_pkg.sv
// ----------------------------------------------------------------------------
// esad_pkg
// Shared types for the exchange sorter: transaction payloads, chain slot
// and per-cell control.
// ----------------------------------------------------------------------------
package esad_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
        logic                      overflow;
    } t_out_item;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic insert;
        logic shift_left;
        logic shift_right;
    } t_cell_ctl;

endpackage

### rtl/esad_cell.sv
// ----------------------------------------------------------------------------
// esad_cell
// One slot of the sorting chain. Keeps the row in ascending order on insert
// and moves its element to a neighbor while the row is unloaded.
// ----------------------------------------------------------------------------
module esad_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  esad_pkg::t_cell_ctl               i_ctl,
    input  logic signed [esad_pkg::VALUE_W-1:0] i_din,
    input  esad_pkg::t_slot                   i_left,
    input  logic                              i_left_take,
    input  esad_pkg::t_slot                   i_right,
    output esad_pkg::t_slot                   o_slot,
    output logic                              o_take
);
    import esad_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    assign o_take = !r_slot.valid || (i_din < r_slot.value);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        priority if (i_ctl.insert) begin
            if (o_take) begin
                if (i_left_take) begin
                    n_slot = i_left;
                end else begin
                    n_slot.valid = 1'b1;
                    n_slot.value = i_din;
                end
            end
        end else if (i_ctl.shift_left) begin
            n_slot = i_right;
        end else if (i_ctl.shift_right) begin
            n_slot = i_left;
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.value <= n_slot.value;
    end

endmodule

### rtl/exchange_sort_asc_desc.sv
// ----------------------------------------------------------------------------
// exchange_sort_asc_desc
// Load: one element per cycle into a chain of MAX_ITEMS cells (insertion).
// Unload: results start after the last transaction and come one per
// cycle; largest-first first shifts the row to the far end of the chain.
// busy is high from the last transaction until the final result is issued.
// Synchronous reset empties the chain and sets ascending order.
// ----------------------------------------------------------------------------
module exchange_sort_asc_desc #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  esad_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    output logic                o_res_strobe,
    output esad_pkg::t_out_item o_res
);
    import esad_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic             r_ascending;
    logic             r_desc;
    logic             r_res_strobe;
    t_out_item        r_res;

    t_cell_ctl        w_ctl;
    t_slot            w_slot [MAX_ITEMS];
    logic             w_take [MAX_ITEMS];
    logic             w_accept;
    logic             w_room;
    logic             w_emit;
    logic             w_final;
    t_slot            w_head;
    t_slot            w_empty;

    assign busy         = (r_state == S_EMIT);
    assign w_accept     = start && !busy;
    assign w_room       = (r_count < CNT_W'(MAX_ITEMS));
    assign w_empty      = '0;
    assign w_head       = r_desc ? w_slot[MAX_ITEMS-1] : w_slot[0];
    assign w_emit       = (r_state == S_EMIT) && w_head.valid;
    assign w_final      = w_emit && (r_count == CNT_W'(1));

    assign w_ctl.insert      = w_accept && w_room;
    assign w_ctl.shift_left  = (r_state == S_EMIT) && !r_desc;
    assign w_ctl.shift_right = (r_state == S_EMIT) && r_desc;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        esad_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_din       (i_item.value),
            .i_left      ((g == 0) ? w_empty : w_slot[(g == 0) ? 0 : g-1]),
            .i_left_take ((g == 0) ? 1'b0 : w_take[(g == 0) ? 0 : g-1]),
            .i_right     ((g == MAX_ITEMS-1) ? w_empty
                                             : w_slot[(g == MAX_ITEMS-1) ? g : g+1]),
            .o_slot      (w_slot[g]),
            .o_take      (w_take[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascending <= 1'b1;
        end else if (i_cfg_we) begin
            r_ascending <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_desc       <= 1'b0;
            r_res_strobe <= 1'b0;
            r_res        <= '0;
        end else begin
            r_res_strobe    <= w_emit;
            r_res.value_res <= w_head.value;
            r_res.last_res  <= w_final;
            r_res.overflow  <= w_final && r_dropped;
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_item.last) begin
                            r_desc  <= !r_ascending;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    if (w_final || r_count == '0) begin
                        r_dropped <= 1'b0;
                        r_state   <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

endmodule
